// ===== sv/bcsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsc_pkg: shared types and constants of the charge stage controller
// Charger stages, window job record, threshold bundle and register indexes.
// ----------------------------------------------------------------------------
package bcsc_pkg;

  localparam int SAMPLE_W   = 10;  // adc count width
  localparam int RATIO_W    = 16;  // q8.8 divider ratio
  localparam int SCALED_W   = SAMPLE_W + RATIO_W - 8;
  localparam int CUR_W      = 17;  // current window sum
  localparam int VOLT_W     = 27;  // signed voltage window sum
  localparam int CUR_THR_W  = 17;
  localparam int VOLT_THR_W = 26;
  localparam int CNT_W      = 7;   // sample counter
  localparam int DUTY_W     = 8;
  localparam int STAGE_W    = 2;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 26;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DUTY_W-1:0] DUTY_MIN = DUTY_W'(1);
  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(255);

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_RATIO        = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_LIMIT        = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRECHARGE_CURRENT    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BULK_ENTRY_VOLTAGE   = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ABSORB_ENTRY_VOLTAGE = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ABSORB_VOLTAGE       = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FLOAT_ENTRY_CURRENT  = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_FLOAT_VOLTAGE        = 4'd7;

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(256);

  typedef enum logic [STAGE_W-1:0] {
    ST_DISCHARGED = 2'd0,
    ST_BULK       = 2'd1,
    ST_OVERCHARGE = 2'd2,
    ST_FLOAT      = 2'd3
  } stage_t;

  // one entry of the queue between front and back
  typedef struct packed {
    logic                     restart;
    logic [CUR_W-1:0]         cur_sum;
    logic signed [VOLT_W-1:0] volt_sum;
  } job_t;

  typedef struct packed {
    logic [CUR_THR_W-1:0]  current_limit;
    logic [CUR_THR_W-1:0]  precharge_current;
    logic [VOLT_THR_W-1:0] bulk_entry_voltage;
    logic [VOLT_THR_W-1:0] absorb_entry_voltage;
    logic [VOLT_THR_W-1:0] absorb_voltage;
    logic [CUR_THR_W-1:0]  float_entry_current;
    logic [VOLT_THR_W-1:0] float_voltage;
  } thresh_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== sv/bcsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsc_front: sample intake and window accumulation
// Scales the sense sample, sums the window and posts a job per window end
// or restart.
// ----------------------------------------------------------------------------
module bcsc_front #(
  parameter int WINDOW = 100
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_restart,
  input  logic [bcsc_pkg::SAMPLE_W-1:0]     in_shunt,
  input  logic [bcsc_pkg::SAMPLE_W-1:0]     in_sense,
  input  logic [bcsc_pkg::RATIO_W-1:0]      voltage_ratio,
  input  bcsc_pkg::queue_status_t           q_status,
  output logic                              q_push,
  output bcsc_pkg::job_t                    q_job
);

  localparam int PROD_W = bcsc_pkg::SAMPLE_W + bcsc_pkg::RATIO_W;
  localparam int TERM_W = bcsc_pkg::SCALED_W + 1;
  localparam logic [bcsc_pkg::CNT_W-1:0] LAST_COUNT = bcsc_pkg::CNT_W'(WINDOW - 1);

  // stage 1: registered product
  logic                              s1_valid;
  logic                              s1_restart;
  logic [bcsc_pkg::SAMPLE_W-1:0]     s1_shunt;
  logic [bcsc_pkg::SCALED_W-1:0]     s1_scaled;

  logic [bcsc_pkg::CNT_W-1:0]        sample_count;
  logic [bcsc_pkg::CUR_W-1:0]        current_sum;
  logic signed [bcsc_pkg::VOLT_W-1:0] voltage_sum;

  logic [PROD_W-1:0]                 product;
  logic signed [TERM_W-1:0]          term;
  logic [bcsc_pkg::CUR_W-1:0]        current_sum_next;
  logic signed [bcsc_pkg::VOLT_W-1:0] voltage_sum_next;
  logic                              window_end;
  logic                              makes_job;
  logic                              commit;
  logic                              load;

  assign product = PROD_W'(in_sense) * PROD_W'(voltage_ratio);

  assign term = $signed({1'b0, s1_scaled})
              - $signed({{(TERM_W - bcsc_pkg::SAMPLE_W){1'b0}}, s1_shunt});
  assign current_sum_next = current_sum + bcsc_pkg::CUR_W'(s1_shunt);
  assign voltage_sum_next = voltage_sum + bcsc_pkg::VOLT_W'(term);

  assign window_end = (sample_count == LAST_COUNT);
  assign makes_job  = s1_restart || window_end;
  assign commit     = s1_valid && (!makes_job || !q_status.full);
  assign in_ready   = !s1_valid || commit;
  assign load       = in_valid && in_ready;

  assign q_push           = commit && makes_job;
  assign q_job.restart    = s1_restart;
  assign q_job.cur_sum    = current_sum_next;
  assign q_job.volt_sum   = voltage_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_restart <= in_restart;
      s1_shunt   <= in_shunt;
      s1_scaled  <= product[PROD_W-1:8];
    end
  end

  // restart leaves the window in progress alone
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      current_sum  <= '0;
      voltage_sum  <= '0;
    end else if (commit && !s1_restart) begin
      if (window_end) begin
        sample_count <= '0;
        current_sum  <= '0;
        voltage_sum  <= '0;
      end else begin
        sample_count <= sample_count + 1'b1;
        current_sum  <= current_sum_next;
        voltage_sum  <= voltage_sum_next;
      end
    end
  end

endmodule

// ===== sv/bcsc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsc_fifo: job queue between front and back
// Small register queue; push is refused while full.
// ----------------------------------------------------------------------------
module bcsc_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  bcsc_pkg::job_t          push_job,
  input  logic                    pop,
  output bcsc_pkg::job_t          head_job,
  output bcsc_pkg::queue_status_t status
);

  localparam int PTR_W = $clog2(bcsc_pkg::QUEUE_DEPTH);
  localparam int LVL_W = $clog2(bcsc_pkg::QUEUE_DEPTH + 1);

  bcsc_pkg::job_t     entries [bcsc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LVL_W-1:0]   level;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (level == LVL_W'(bcsc_pkg::QUEUE_DEPTH));
  assign status.empty = (level == '0);
  assign do_push  = push && !status.full;
  assign do_pop   = pop && !status.empty;
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(bcsc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(bcsc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// ===== sv/bcsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsc_back: charger stage machine and result register
// Runs one stage update per job and holds the result until taken.
// ----------------------------------------------------------------------------
module bcsc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bcsc_pkg::queue_status_t       q_status,
  input  bcsc_pkg::job_t                q_job,
  output logic                          q_pop,
  input  bcsc_pkg::thresh_t             thr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bcsc_pkg::DUTY_W-1:0]   out_duty,
  output bcsc_pkg::stage_t              out_stage
);

  localparam int CMP_W = bcsc_pkg::VOLT_W + 1;

  bcsc_pkg::stage_t              charge_stage;
  bcsc_pkg::stage_t              charge_stage_next;
  logic [bcsc_pkg::DUTY_W-1:0]   duty_value;
  logic [bcsc_pkg::DUTY_W-1:0]   duty_value_next;

  logic signed [CMP_W-1:0]       v;
  logic signed [CMP_W-1:0]       bulk_thr;
  logic signed [CMP_W-1:0]       absorb_entry_thr;
  logic signed [CMP_W-1:0]       absorb_thr;
  logic signed [CMP_W-1:0]       float_thr;
  logic                          below_limit;
  logic                          step_up;

  assign q_pop = !q_status.empty && (!out_valid || out_ready);

  assign v                = CMP_W'(q_job.volt_sum);
  assign bulk_thr         = $signed({2'b00, thr.bulk_entry_voltage});
  assign absorb_entry_thr = $signed({2'b00, thr.absorb_entry_voltage});
  assign absorb_thr       = $signed({2'b00, thr.absorb_voltage});
  assign float_thr        = $signed({2'b00, thr.float_voltage});
  assign below_limit      = q_job.cur_sum < thr.current_limit;

  always_comb begin
    charge_stage_next = charge_stage;
    step_up           = 1'b0;
    case (charge_stage)
      bcsc_pkg::ST_DISCHARGED: begin
        step_up = below_limit && (q_job.cur_sum < thr.precharge_current);
        if (v > bulk_thr) begin
          charge_stage_next = bcsc_pkg::ST_BULK;
        end
      end
      bcsc_pkg::ST_BULK: begin
        step_up = below_limit;
        if (v > absorb_entry_thr) begin
          charge_stage_next = bcsc_pkg::ST_OVERCHARGE;
        end
      end
      bcsc_pkg::ST_OVERCHARGE: begin
        step_up = below_limit && (v < absorb_thr);
        if (q_job.cur_sum < thr.float_entry_current) begin
          charge_stage_next = bcsc_pkg::ST_FLOAT;
        end
      end
      default: begin
        step_up = below_limit && !(v > float_thr);
      end
    endcase

    // saturating duty step
    if (step_up) begin
      duty_value_next = (duty_value == bcsc_pkg::DUTY_MAX) ? duty_value : duty_value + 1'b1;
    end else begin
      duty_value_next = (duty_value == bcsc_pkg::DUTY_MIN) ? duty_value : duty_value - 1'b1;
    end

    if (q_job.restart) begin
      charge_stage_next = bcsc_pkg::ST_DISCHARGED;
      duty_value_next   = bcsc_pkg::DUTY_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_stage <= bcsc_pkg::ST_DISCHARGED;
      duty_value   <= bcsc_pkg::DUTY_MIN;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        charge_stage <= charge_stage_next;
        duty_value   <= duty_value_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_duty  <= duty_value_next;
      out_stage <= charge_stage_next;
    end
  end

endmodule

// ===== sv/battery_charge_stage_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_stage_controller: four-stage lead-acid charge controller
// Windowed shunt / sense accumulation driving a stepped pwm duty.
// ----------------------------------------------------------------------------
// usage
//   input beats carry one adc pair (tuser low) or a restart (tuser high)
//   every WINDOW sample beats give one output beat with the new duty and
//   stage; a restart gives one output beat (duty 1, discharged) and leaves
//   the window in progress untouched; other beats give no output
//   thresholds are window sums in adc counts, written on the cfg port
//   only while the block is idle
// timing
//   one input beat per cycle sustained while the job queue has room; the beat
//   that causes an output beat passes the multiply register, the window adder
//   into the job queue and the stage machine into the output register
//   a four-entry job queue sits between the window adder and the stage
//   machine, so input keeps flowing while an output beat waits
// reset and stall
//   rst clears the window, the queue, the stage (discharged), the duty (1)
//   and the registers (ratio 256, thresholds 0)
//   when m_tready stays low the queue fills and then s_tready drops
// ----------------------------------------------------------------------------
module battery_charge_stage_controller #(
  parameter int WINDOW = 100  // samples per window, 1 to 128
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,  // shunt_sample, sense_sample
  input  logic                                s_tuser,  // action
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,  // pwm_duty, stage
  // configuration
  input  logic                                cfg_we,
  input  logic [bcsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bcsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [bcsc_pkg::RATIO_W-1:0]  voltage_ratio;
  bcsc_pkg::thresh_t             thr;

  bcsc_pkg::queue_status_t       q_status;
  bcsc_pkg::job_t                push_job;
  bcsc_pkg::job_t                head_job;
  logic                          q_push;
  logic                          q_pop;

  logic [bcsc_pkg::DUTY_W-1:0]   out_duty;
  bcsc_pkg::stage_t              out_stage;

  // configuration registers, values masked to their widths
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_ratio <= bcsc_pkg::RATIO_RESET;
      thr           <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcsc_pkg::REG_VOLTAGE_RATIO:
          voltage_ratio <= cfg_data[bcsc_pkg::RATIO_W-1:0];
        bcsc_pkg::REG_CURRENT_LIMIT:
          thr.current_limit <= cfg_data[bcsc_pkg::CUR_THR_W-1:0];
        bcsc_pkg::REG_PRECHARGE_CURRENT:
          thr.precharge_current <= cfg_data[bcsc_pkg::CUR_THR_W-1:0];
        bcsc_pkg::REG_BULK_ENTRY_VOLTAGE:
          thr.bulk_entry_voltage <= cfg_data[bcsc_pkg::VOLT_THR_W-1:0];
        bcsc_pkg::REG_ABSORB_ENTRY_VOLTAGE:
          thr.absorb_entry_voltage <= cfg_data[bcsc_pkg::VOLT_THR_W-1:0];
        bcsc_pkg::REG_ABSORB_VOLTAGE:
          thr.absorb_voltage <= cfg_data[bcsc_pkg::VOLT_THR_W-1:0];
        bcsc_pkg::REG_FLOAT_ENTRY_CURRENT:
          thr.float_entry_current <= cfg_data[bcsc_pkg::CUR_THR_W-1:0];
        bcsc_pkg::REG_FLOAT_VOLTAGE:
          thr.float_voltage <= cfg_data[bcsc_pkg::VOLT_THR_W-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // front: scaling and window sums
  bcsc_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_restart    (s_tuser),
    .in_shunt      (s_tdata[9:0]),
    .in_sense      (s_tdata[19:10]),
    .voltage_ratio (voltage_ratio),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  // job queue
  bcsc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // back: stage machine and output register
  bcsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .thr       (thr),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_duty  (out_duty),
    .out_stage (out_stage)
  );

  assign m_tdata = {6'b0, out_stage, out_duty};

`ifndef ASSERT_OFF
  // duty never leaves its floor
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> (m_tdata[7:0] != 8'd0))
    else $error("pwm duty of zero on output");

  // output register is empty straight after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid after reset");

  // queue cannot be full and empty at once
  assert property (@(posedge clk) disable iff (rst) !(q_status.full && q_status.empty))
    else $error("job queue both full and empty");

  // a pop always lands in the output register
  assert property (@(posedge clk) disable iff (rst) q_pop |=> m_tvalid)
    else $error("job popped without output beat");
`endif

endmodule
